### design/keyed_usage_aggregation_table_defines.svh
// Assertion macros used by the checker file
`ifndef KEYED_USAGE_AGGREGATION_TABLE_DEFINES_SVH
`define KEYED_USAGE_AGGREGATION_TABLE_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define KUAT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define KUAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### design/kuat_pkg.sv
// Package: types, constants and helpers of the usage aggregation table
package kuat_pkg;
    localparam int BUCKETS    = 256;
    localparam int WAYS       = 4;
    localparam int FRAC_BITS  = 8;
    localparam int BKT_W      = $clog2(BUCKETS);
    localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENTRIES    = BUCKETS * WAYS;
    localparam int ENT_W      = $clog2(ENTRIES);
    localparam int KEY_W      = 50;
    localparam int OP_W       = 16;
    localparam int CNT_W      = 48;
    localparam int SMS_W      = 32;
    // one stored entry: key, operator, 4 voice, 4 sms, 2 data tallies
    localparam int ROW_W      = KEY_W + OP_W + 4 * CNT_W + 4 * SMS_W + 2 * CNT_W;

    localparam logic [2:0] KIND_VOICE_OUT = 3'd0;
    localparam logic [2:0] KIND_VOICE_IN  = 3'd1;
    localparam logic [2:0] KIND_SMS_OUT   = 3'd2;
    localparam logic [2:0] KIND_SMS_IN    = 3'd3;
    localparam logic [2:0] KIND_DATA      = 3'd4;

    localparam logic [1:0] ST_UPDATED = 2'd0;
    localparam logic [1:0] ST_CREATED = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;
    localparam logic [1:0] ST_READ    = 2'd3;

    localparam logic [3:0] PICK_TOTAL = 4'd10;

    typedef struct packed {
        logic        mode;
        logic [49:0] subscriber;
        logic [15:0] home_operator;
        logic [15:0] peer_operator;
        logic [2:0]  usage_kind;
        logic [31:0] call_length;
        logic [31:0] bytes_down;
        logic [31:0] bytes_up;
        logic [7:0]  read_bucket;
        logic [1:0]  read_way;
        logic [3:0]  counter_pick;
    } kuat_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        entry_valid;
        logic [49:0] entry_key;
        logic [15:0] entry_operator;
        logic [47:0] counter_value;
    } kuat_out_t;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [OP_W-1:0]     op;
        logic [3:0][CNT_W-1:0] voice;
        logic [3:0][SMS_W-1:0] sms;
        logic [1:0][CNT_W-1:0] data;
    } kuat_row_t;

    // saturating 48-bit add of a 32-bit amount
    function automatic logic [CNT_W-1:0] add_sat48(logic [CNT_W-1:0] a, logic [31:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {{(CNT_W-31){1'b0}}, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    // saturating 32-bit increment
    function automatic logic [SMS_W-1:0] inc_sat32(logic [SMS_W-1:0] a);
        return (&a) ? a : a + 1'b1;
    endfunction
endpackage

### design/kuat_ram.sv
// Generic single-port-write, one-read synchronous RAM with registered read
module kuat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### design/kuat_update.sv
// Way match and tally update logic for one bucket row
module kuat_update import kuat_pkg::*; (
    input  kuat_in_t                   item,
    input  logic [WAYS-1:0]            valid_row,
    input  kuat_row_t [WAYS-1:0]       rows,
    output logic [1:0]                 status,
    output logic [WAY_W-1:0]           way,
    output logic                       do_write,
    output kuat_row_t                  new_row
);
    logic             hit;
    logic             free;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] free_way;
    logic             other;
    kuat_row_t        base;

    // first matching way and first free way
    always_comb
    begin
        hit      = 1'b0;
        free     = 1'b0;
        hit_way  = '0;
        free_way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (valid_row[w])
            begin
                if (!hit && rows[w].key == item.subscriber)
                begin
                    hit     = 1'b1;
                    hit_way = WAY_W'(w);
                end
            end
            else if (!free)
            begin
                free     = 1'b1;
                free_way = WAY_W'(w);
            end
        end
    end

    // pick entry, zero it on create, then add the record
    always_comb
    begin
        other    = (item.home_operator != item.peer_operator);
        do_write = hit || free;
        way      = hit ? hit_way : free_way;
        status   = hit ? ST_UPDATED : (free ? ST_CREATED : ST_DROPPED);
        if (hit)
        begin
            base = rows[hit_way];
        end
        else
        begin
            base     = '0;
            base.key = item.subscriber;
            base.op  = item.home_operator;
        end
        new_row = base;
        case (item.usage_kind)
            KIND_VOICE_OUT: new_row.voice[{1'b0, other}] =
                add_sat48(base.voice[{1'b0, other}], item.call_length);
            KIND_VOICE_IN:  new_row.voice[{1'b1, other}] =
                add_sat48(base.voice[{1'b1, other}], item.call_length);
            KIND_SMS_OUT:   new_row.sms[{1'b0, other}] = inc_sat32(base.sms[{1'b0, other}]);
            KIND_SMS_IN:    new_row.sms[{1'b1, other}] = inc_sat32(base.sms[{1'b1, other}]);
            KIND_DATA:
            begin
                new_row.data[0] = add_sat48(base.data[0], item.bytes_down);
                new_row.data[1] = add_sat48(base.data[1], item.bytes_up);
            end
            default: ;
        endcase
    end
endmodule

### design/keyed_usage_aggregation_table.sv
// A word reads its bucket when it is accepted, and its result word is registered
// from the read row once the output register is free. One word is in flight: the
// read-modify-write of the bucket memory keeps the input stalled until the result
// of the last word is registered. A stalled result lets the next word in but holds
// its completion. Reset clears the record total at once and starts a pass that
// clears all 256 buckets of the way valid memory, with the input stalled.
module keyed_usage_aggregation_table import kuat_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  kuat_in_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output kuat_out_t out_data
);
    localparam int BANK_W = ROW_W * WAYS;

    logic [31:0]        total_reg;
    logic               busy_reg;
    kuat_in_t           item_reg;
    logic               out_valid_reg;
    kuat_out_t          out_reg;
    logic               clr_reg;
    logic [BKT_W-1:0]   clr_addr_reg;

    logic               accept;
    logic               out_free;
    logic [BKT_W-1:0]   rd_bkt;
    logic [BKT_W-1:0]   bkt;
    logic [BKT_W-1:0]   raddr;
    logic [BANK_W-1:0]  rd_word;
    kuat_row_t [WAYS-1:0] rows;
    kuat_row_t [WAYS-1:0] wr_rows;
    logic [WAYS-1:0]    valid_row;
    logic               v_we;
    logic [BKT_W-1:0]   v_waddr;
    logic [WAYS-1:0]    v_wdata;
    logic [1:0]         upd_status;
    logic [WAY_W-1:0]   upd_way;
    logic               upd_write;
    kuat_row_t          upd_row;
    logic               we;
    kuat_out_t          res;
    logic               rd_ok;
    kuat_row_t          rrow;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = busy_reg || clr_reg;
    assign accept   = in_valid && !in_stall;
    assign rd_bkt   = in_data.mode ? in_data.read_bucket[BKT_W-1:0]
                                   : in_data.subscriber[BKT_W-1:0];
    assign bkt      = item_reg.mode ? item_reg.read_bucket[BKT_W-1:0]
                                    : item_reg.subscriber[BKT_W-1:0];
    // hold the read address on the current word while it waits
    assign raddr    = busy_reg ? bkt : rd_bkt;

    // bucket memory, one row of all ways per address
    kuat_ram #(.WIDTH(BANK_W), .DEPTH(BUCKETS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (bkt),
        .wdata (wr_rows),
        .raddr (raddr),
        .rdata (rd_word)
    );
    assign rows = rd_word;

    // way valid memory, one bit per way, cleared after reset
    kuat_ram #(.WIDTH(WAYS), .DEPTH(BUCKETS)) u_vram (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (raddr),
        .rdata (valid_row)
    );

    kuat_update u_upd (
        .item      (item_reg),
        .valid_row (valid_row),
        .rows      (rows),
        .status    (upd_status),
        .way       (upd_way),
        .do_write  (upd_write),
        .new_row   (upd_row)
    );

    assign we      = busy_reg && out_free && !item_reg.mode && upd_write;
    assign v_we    = clr_reg || we;
    assign v_waddr = clr_reg ? clr_addr_reg : bkt;
    assign v_wdata = clr_reg ? '0 : (valid_row | (WAYS'(1) << upd_way));

    always_comb
    begin
        wr_rows = rows;
        wr_rows[upd_way] = upd_row;
    end

    // read-mode result and record result
    always_comb
    begin
        rd_ok  = (32'(item_reg.read_bucket) < 32'(BUCKETS)) &&
                 (32'(item_reg.read_way) < 32'(WAYS));
        rrow   = rows[item_reg.read_way[WAY_W-1:0]];
        res    = '0;
        if (item_reg.mode)
        begin
            res.status = ST_READ;
            if (rd_ok && valid_row[item_reg.read_way[WAY_W-1:0]])
            begin
                res.entry_valid    = 1'b1;
                res.entry_key      = rrow.key;
                res.entry_operator = rrow.op;
                case (item_reg.counter_pick) inside
                    [4'd0:4'd3]:
                        res.counter_value = rrow.voice[item_reg.counter_pick[1:0]];
                    [4'd4:4'd7]:
                        res.counter_value = {16'd0, rrow.sms[item_reg.counter_pick[1:0]]};
                    [4'd8:4'd9]:
                        res.counter_value = rrow.data[item_reg.counter_pick[0]];
                    default: res.counter_value = '0;
                endcase
            end
            if (item_reg.counter_pick == PICK_TOTAL)
            begin
                res.counter_value = {16'd0, total_reg};
            end
        end
        else
        begin
            res.status = upd_status;
        end
    end

    // clearing pass over the valid memory
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == BKT_W'(BUCKETS - 1))
            begin
                clr_reg <= 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && out_free)
            begin
                busy_reg      <= 1'b0;
                out_valid_reg <= 1'b1;
                if (we)
                begin
                    total_reg <= inc_sat32(total_reg);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
        if (busy_reg && out_free)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
endmodule

### design/kuat_checker.sv
// Port-level checker for the usage aggregation table, bound to the top level
`include "keyed_usage_aggregation_table_defines.svh"
module kuat_checker import kuat_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input kuat_in_t  in_data,
    input logic      out_valid,
    input logic      out_stall,
    input kuat_out_t out_data
);
    `KUAT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
    `KUAT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    `KUAT_ASSERT_IMPL(a_record_fields_zero, clk, rst_n, out_valid && out_data.status != ST_READ, !out_data.entry_valid && out_data.counter_value == '0)
    `KUAT_ASSERT_IMPL(a_free_way_zero, clk, rst_n, out_valid && out_data.status == ST_READ && !out_data.entry_valid, out_data.entry_key == '0 && out_data.entry_operator == '0)
endmodule

bind keyed_usage_aggregation_table kuat_checker u_kuat_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
